FILE: sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, operation codes, controller states and the result word type
// of the bitmap set engine.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int OP_W     = 4;
   localparam int MEMBER_W = 10;
   localparam int WIDX_W   = 4;
   localparam int VALUE_W  = 64;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 4'd0,
      OP_REMOVE = 4'd1,
      OP_TEST   = 4'd2,
      OP_CLEAR  = 4'd3,
      OP_FILL   = 4'd4,
      OP_EMPTY  = 4'd5,
      OP_FIRST  = 4'd6,
      OP_NEXT   = 4'd7,
      OP_OR     = 4'd8,
      OP_AND    = 4'd9,
      OP_ANDNOT = 4'd10
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_MODIFY,
      ST_SWEEP,
      ST_ERD,
      ST_ECHK,
      ST_SRD,
      ST_SFF1,
      ST_SFF2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                flag;
      logic                found;
      logic [MEMBER_W-1:0] found_member;
      logic                out_of_range;
   } rsp_type;

endpackage

FILE: sv/bse_req_if.sv
// ----------------------------------------------------------------------------
// bse_req_if
// Request channel: one operation word with its member and merge operands.
// ----------------------------------------------------------------------------
interface bse_req_if;

   logic                         valid;
   logic                         ready;
   logic [bse_pkg::OP_W-1:0]     op;
   logic [bse_pkg::MEMBER_W-1:0] member;
   logic [bse_pkg::WIDX_W-1:0]   word_index;
   logic [bse_pkg::VALUE_W-1:0]  word_value;

   modport source (output valid, op, member, word_index, word_value, input ready);
   modport sink (input valid, op, member, word_index, word_value, output ready);

endinterface

FILE: sv/bse_rsp_if.sv
// ----------------------------------------------------------------------------
// bse_rsp_if
// Response channel: one result word for every request word.
// ----------------------------------------------------------------------------
interface bse_rsp_if;

   logic                         valid;
   logic                         ready;
   logic                         flag;
   logic                         found;
   logic [bse_pkg::MEMBER_W-1:0] found_member;
   logic                         out_of_range;

   modport source (output valid, flag, found, found_member, out_of_range, input ready);
   modport sink (input valid, flag, found, found_member, out_of_range, output ready);

endinterface

FILE: sv/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bse_split.sv
// ----------------------------------------------------------------------------
// bse_split
// Splits a member number into word and bit position. The first stage
// multiplies by a scaled reciprocal of the word size; the second forms the
// remainder and corrects the quotient by at most one.
// ----------------------------------------------------------------------------
module bse_split #(
   parameter int WORD_BITS = 64,
   parameter int BW        = $clog2(WORD_BITS)
) (
   input  logic                         clock,
   input  logic [bse_pkg::MEMBER_W-1:0] member,
   output logic [bse_pkg::MEMBER_W-1:0] word,
   output logic [BW-1:0]                bit_pos
);

   import bse_pkg::*;

   localparam int SHIFT = 16;
   localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW    = $clog2(RECIP + 1);
   localparam int PRW   = MEMBER_W + RW;
   localparam int XW    = MEMBER_W + 7;

   logic [PRW-1:0]      prod;
   logic [MEMBER_W-1:0] q_ff;
   logic [MEMBER_W-1:0] member_ff;
   logic [XW-1:0]       qm;
   logic [XW-1:0]       rem;

   assign prod = PRW'(member) * PRW'(RECIP);

   always_ff @(posedge clock) begin
      q_ff      <= MEMBER_W'(prod >> SHIFT);
      member_ff <= member;
   end

   always_comb begin
      qm  = XW'(q_ff) * XW'(WORD_BITS);
      rem = XW'(member_ff) - qm;
      if (rem >= XW'(WORD_BITS)) begin
         word    = q_ff + MEMBER_W'(1);
         bit_pos = BW'(rem - XW'(WORD_BITS));
      end else begin
         word    = q_ff;
         bit_pos = BW'(rem);
      end
   end

endmodule

FILE: sv/bse_ffs.sv
// ----------------------------------------------------------------------------
// bse_ffs
// Two-stage search for the lowest set bit of a word at or above a start bit.
// Stage one finds the lowest bit in each byte lane and registers it; stage
// two picks the lowest lane that has a hit.
// ----------------------------------------------------------------------------
module bse_ffs #(
   parameter int WORD_BITS = 64,
   parameter int BW        = $clog2(WORD_BITS)
) (
   input  logic                 clock,
   input  logic [WORD_BITS-1:0] word,
   input  logic [BW-1:0]        start_bit,
   output logic                 hit,
   output logic [BW-1:0]        hit_pos
);

   localparam int NG = (WORD_BITS + 7) / 8;

   logic [NG*8-1:0] kept;
   logic [NG-1:0]   any_in;
   logic [2:0]      idx_in [NG];
   logic [NG-1:0]   any_ff;
   logic [2:0]      idx_ff [NG];

   always_comb begin
      kept = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         kept[i] = word[i] && (i >= int'(start_bit));
      end
      for (int g = 0; g < NG; g++) begin
         any_in[g] = |kept[g*8 +: 8];
         idx_in[g] = 3'd0;
         for (int j = 7; j >= 0; j--) begin
            if (kept[g*8 + j]) begin
               idx_in[g] = 3'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      any_ff <= any_in;
      for (int g = 0; g < NG; g++) begin
         idx_ff[g] <= idx_in[g];
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            hit     = 1'b1;
            hit_pos = BW'(g * 8 + int'(idx_ff[g]));
         end
      end
   end

endmodule

FILE: sv/bitmap_set_engine.sv
// ----------------------------------------------------------------------------
// bitmap_set_engine
// Bitmap set of WORDS * WORD_BITS members held in a word RAM.
//
// The req_ch channel takes one operation word per handshake: insert, remove
// or test a member, clear or fill the set, test for empty, restart or advance
// the iterator, or merge a word of another set by OR, AND or AND-NOT. The
// rsp_ch channel returns exactly one result word for each request word.
// The engine works on one request at a time. Insert, remove and the merges
// read a word in range from the RAM and write it back; test reads only, and
// clear and fill write every word. Empty reads the words in order and stops
// at the first nonzero word; first and next scan word by word from the
// iterator. Another request is taken in the cycle after the result is loaded.
// After reset the engine clears the RAM, one word per cycle, before
// req_ch.ready rises; the iterator restarts at member zero.
// The result sits in an output register: a stalled receiver does not block
// the next request, but a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module bitmap_set_engine #(
   parameter int WORD_BITS = 64,
   parameter int WORDS     = 16
) (
   input  logic  clock,
   input  logic  reset,
   bse_req_if.sink   req_ch,
   bse_rsp_if.source rsp_ch
);

   import bse_pkg::*;

   localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW  = $clog2(WORD_BITS);
   localparam int CWW = $clog2(WORDS + 1);
   localparam int PW  = $clog2(WORDS * WORD_BITS + 1);

   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   op_type               op_ff, op_in;
   logic [MEMBER_W-1:0]  member_ff, member_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [WORD_BITS-1:0] wv_ff, wv_in;
   logic [BW-1:0]        mb_ff, mb_in;
   logic [CWW-1:0]       cur_word_ff, cur_word_in;
   logic [BW-1:0]        cur_bit_ff, cur_bit_in;
   logic [PW-1:0]        cur_base_ff, cur_base_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;
   logic [MEMBER_W-1:0]  split_word;
   logic [BW-1:0]        split_bit;
   logic                 ffs_hit;
   logic [BW-1:0]        ffs_pos;
   logic                 accept;
   op_type               req_op;

   bse_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bse_split #(
      .WORD_BITS (WORD_BITS)
   ) u_split (
      .clock   (clock),
      .member  (member_ff),
      .word    (split_word),
      .bit_pos (split_bit)
   );

   bse_ffs #(
      .WORD_BITS (WORD_BITS)
   ) u_ffs (
      .clock     (clock),
      .word      (rd_data),
      .start_bit (cur_bit_ff),
      .hit       (ffs_hit),
      .hit_pos   (ffs_pos)
   );

   assign req_op = op_type'(req_ch.op);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      member_in    = member_ff;
      addr_in      = addr_ff;
      wv_in        = wv_ff;
      mb_in        = mb_ff;
      cur_word_in  = cur_word_ff;
      cur_bit_in   = cur_bit_ff;
      cur_base_in  = cur_base_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      req_ch.ready = 1'b0;

      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (cnt_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in     = req_op;
               member_in = req_ch.member;
               addr_in   = AW'(req_ch.word_index);
               wv_in     = req_ch.word_value[WORD_BITS-1:0];
               res_in    = '0;
               cnt_in    = '0;
               case (req_op)
                  OP_INSERT, OP_REMOVE, OP_TEST: begin
                     state_in = ST_DIV;
                  end
                  OP_CLEAR, OP_FILL: begin
                     state_in = ST_SWEEP;
                  end
                  OP_EMPTY: begin
                     state_in = ST_ERD;
                  end
                  OP_FIRST: begin
                     cur_word_in = '0;
                     cur_bit_in  = '0;
                     cur_base_in = '0;
                     state_in    = ST_SRD;
                  end
                  OP_NEXT: begin
                     state_in = ST_DONE;
                     if (cur_word_ff != CWW'(WORDS)) begin
                        if (cur_bit_ff == BW'(WORD_BITS - 1)) begin
                           cur_word_in = cur_word_ff + CWW'(1);
                           cur_bit_in  = '0;
                           cur_base_in = cur_base_ff + PW'(WORD_BITS);
                           if (cur_word_ff + CWW'(1) != CWW'(WORDS)) begin
                              state_in = ST_SRD;
                           end
                        end else begin
                           cur_bit_in = cur_bit_ff + BW'(1);
                           state_in   = ST_SRD;
                        end
                     end
                  end
                  OP_OR, OP_AND, OP_ANDNOT: begin
                     if (32'(req_ch.word_index) < 32'(WORDS)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_ch.word_index);
                        state_in = ST_MODIFY;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            mb_in   = split_bit;
            addr_in = AW'(split_word);
            if (32'(split_word) < 32'(WORDS)) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(split_word);
               state_in = ST_MODIFY;
            end else begin
               res_in.out_of_range = (op_ff == OP_INSERT);
               state_in            = ST_DONE;
            end
         end
         ST_MODIFY: begin
            wr_addr  = addr_ff;
            state_in = ST_DONE;
            case (op_ff)
               OP_INSERT: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | (WORD_BITS'(1) << mb_ff);
               end
               OP_REMOVE: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~(WORD_BITS'(1) << mb_ff);
               end
               OP_TEST: begin
                  res_in.flag = rd_data[mb_ff];
               end
               OP_OR: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | wv_ff;
               end
               OP_AND: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & wv_ff;
               end
               OP_ANDNOT: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~wv_ff;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_data = (op_ff == OP_FILL) ? {WORD_BITS{1'b1}} : '0;
            if (cnt_ff == AW'(WORDS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_ERD: begin
            rd_en    = 1'b1;
            state_in = ST_ECHK;
         end
         ST_ECHK: begin
            if (rd_data != '0) begin
               state_in = ST_DONE;
            end else if (cnt_ff == AW'(WORDS - 1)) begin
               res_in.flag = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_ERD;
            end
         end
         ST_SRD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(cur_word_ff);
            state_in = ST_SFF1;
         end
         ST_SFF1: begin
            state_in = ST_SFF2;
         end
         ST_SFF2: begin
            if (ffs_hit) begin
               cur_bit_in          = ffs_pos;
               res_in.found        = 1'b1;
               res_in.found_member = MEMBER_W'(cur_base_ff + PW'(ffs_pos));
               state_in            = ST_DONE;
            end else if (cur_word_ff == CWW'(WORDS - 1)) begin
               cur_word_in = CWW'(WORDS);
               cur_bit_in  = '0;
               state_in    = ST_DONE;
            end else begin
               cur_word_in = cur_word_ff + CWW'(1);
               cur_bit_in  = '0;
               cur_base_in = cur_base_ff + PW'(WORD_BITS);
               state_in    = ST_SRD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         cur_word_ff  <= '0;
         cur_bit_ff   <= '0;
         cur_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_word_ff  <= cur_word_in;
         cur_bit_ff   <= cur_bit_in;
         cur_base_ff  <= cur_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      member_ff <= member_in;
      addr_ff   <= addr_in;
      wv_ff     <= wv_in;
      mb_ff     <= mb_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.flag         = rsp_ff.flag;
   assign rsp_ch.found        = rsp_ff.found;
   assign rsp_ch.found_member = rsp_ff.found_member;
   assign rsp_ch.out_of_range = rsp_ff.out_of_range;

   a_write_states : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_INIT || state_ff == ST_SWEEP || state_ff == ST_MODIFY))
      else $error("word RAM written outside a write state");

   a_cursor_bound : assert property (@(posedge clock) disable iff (reset)
      (32'(cur_word_ff) <= 32'(WORDS)))
      else $error("iterator word beyond the end marker");

   a_cursor_done : assert property (@(posedge clock) disable iff (reset)
      (cur_word_ff == CWW'(WORDS)) |-> (cur_bit_ff == '0))
      else $error("finished iterator holds a nonzero bit position");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start an operation");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && (rsp_ff.flag || rsp_ff.out_of_range)))
      else $error("result carries flags of more than one operation");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap set engine. A directed sequence covers
// every operation, the iterator corner cases and the field extremes; then
// weighted random operations run with random idling on both channels, a
// stretch without idling, and a long receiver stall. Each accepted request
// word updates a local copy of the set, whose result is compared with the
// response words in order.
// ----------------------------------------------------------------------------
module tb_top;

   import bse_pkg::*;

   localparam int SET_WORD_BITS = 64;
   localparam int SET_WORDS     = 16;
   localparam int SET_CAPACITY  = SET_WORD_BITS * SET_WORDS;
   localparam int IDLE_PERCENT  = 15;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 64;
   localparam int STALL_LIMIT   = 3000;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd11;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

   logic clock = 1'b0;
   logic reset;

   bse_req_if req_bus ();
   bse_rsp_if rsp_bus ();

   bitmap_set_engine #(
      .WORD_BITS(SET_WORD_BITS),
      .WORDS(SET_WORDS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   logic [SET_WORD_BITS-1:0] model_words [SET_WORDS];
   int                       model_cursor;
   rsp_type                  expected_results [$];
   int                       fail_count;
   int                       quiet_cycles;
   bit                       calm;
   bit                       hold_rsp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int lowest_member_from(int start);
      for (int p = start; p < SET_CAPACITY; p++) begin
         if (model_words[p / SET_WORD_BITS][p % SET_WORD_BITS])
            return p;
      end
      return SET_CAPACITY;
   endfunction

   function automatic rsp_type apply_set_op(logic [OP_W-1:0] op, logic [MEMBER_W-1:0] member,
                                            logic [WIDX_W-1:0] widx,
                                            logic [VALUE_W-1:0] wval);
      rsp_type r;
      int      w;
      int      b;
      r = '0;
      w = member / SET_WORD_BITS;
      b = member % SET_WORD_BITS;
      case (op)
         OP_INSERT: begin
            if (w < SET_WORDS)
               model_words[w][b] = 1'b1;
            else
               r.out_of_range = 1'b1;
         end
         OP_REMOVE: begin
            if (w < SET_WORDS)
               model_words[w][b] = 1'b0;
         end
         OP_TEST: begin
            if (w < SET_WORDS)
               r.flag = model_words[w][b];
         end
         OP_CLEAR: begin
            foreach (model_words[i])
               model_words[i] = '0;
         end
         OP_FILL: begin
            foreach (model_words[i])
               model_words[i] = '1;
         end
         OP_EMPTY: begin
            r.flag = 1'b1;
            foreach (model_words[i])
               if (model_words[i] != '0)
                  r.flag = 1'b0;
         end
         OP_FIRST, OP_NEXT: begin
            if (op == OP_FIRST)
               model_cursor = lowest_member_from(0);
            else if (model_cursor < SET_CAPACITY)
               model_cursor = lowest_member_from(model_cursor + 1);
            else
               model_cursor = SET_CAPACITY;
            if (model_cursor < SET_CAPACITY) begin
               r.found        = 1'b1;
               r.found_member = model_cursor[MEMBER_W-1:0];
            end
         end
         OP_OR: begin
            if (widx < SET_WORDS)
               model_words[widx] = model_words[widx] | wval;
         end
         OP_AND: begin
            if (widx < SET_WORDS)
               model_words[widx] = model_words[widx] & wval;
         end
         OP_ANDNOT: begin
            if (widx < SET_WORDS)
               model_words[widx] = model_words[widx] & ~wval;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(logic [OP_W-1:0] op, logic [MEMBER_W-1:0] member,
                            logic [WIDX_W-1:0] widx, logic [VALUE_W-1:0] wval);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.op         = op;
      req_bus.member     = member;
      req_bus.word_index = widx;
      req_bus.word_value = wval;
      req_bus.valid      = 1'b1;
      do
         @(posedge clock);
      while (!req_bus.ready);
      expected_results.push_back(apply_set_op(op, member, widx, wval));
      @(negedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return OP_INSERT;
      if (roll < 31) return OP_REMOVE;
      if (roll < 45) return OP_TEST;
      if (roll < 47) return OP_CLEAR;
      if (roll < 48) return OP_FILL;
      if (roll < 53) return OP_EMPTY;
      if (roll < 60) return OP_FIRST;
      if (roll < 82) return OP_NEXT;
      if (roll < 87) return OP_OR;
      if (roll < 92) return OP_AND;
      if (roll < 97) return OP_ANDNOT;
      return OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
   endfunction

   function automatic logic [MEMBER_W-1:0] pick_member();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return MEMBER_W'(SET_WORD_BITS * $urandom_range(SET_WORDS - 1));
         3: return MEMBER_W'(SET_WORD_BITS * $urandom_range(SET_WORDS) - 1);
         default: return MEMBER_W'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(4))
         0: return {$urandom, $urandom};
         1: return 64'd1 << $urandom_range(VALUE_W - 1);
         2: return '1;
         3: return '0;
         default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_random(int count);
      for (int n = 0; n < count; n++)
         send_word(pick_op(), pick_member(), WIDX_W'($urandom), pick_value());
   endtask

   task automatic test_directed_cases();
      send_word(OP_EMPTY,  '0,        '0,    '0);
      send_word(OP_INSERT, '0,        '0,    '0);
      send_word(OP_INSERT, 10'd5,     '0,    '0);
      // Without a prior first the scan starts one past the reset cursor.
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_TEST,   '0,        '0,    '0);
      send_word(OP_TEST,   '1,        '0,    '0);
      send_word(OP_INSERT, '1,        '1,    '1);
      send_word(OP_TEST,   '1,        '0,    '0);
      send_word(OP_FIRST,  '0,        '0,    '0);
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_REMOVE, 10'd5,     '0,    '0);
      send_word(OP_TEST,   10'd5,     '0,    '0);
      // Change the set between iterator steps.
      send_word(OP_FIRST,  '0,        '0,    '0);
      send_word(OP_INSERT, 10'd700,   '0,    '0);
      send_word(OP_NEXT,   '0,        '0,    '0);
      send_word(OP_OR,     '0,        4'd3,  '1);
      send_word(OP_AND,    '0,        4'd3,  64'h0123_4567_89ab_cdef);
      send_word(OP_ANDNOT, '0,        4'd3,  64'h0000_ffff_0000_ffff);
      send_word(OP_AND,    '0,        4'd15, '0);
      send_word(OP_FILL,   '0,        '0,    '0);
      send_word(OP_EMPTY,  '0,        '0,    '0);
      send_word(OP_CLEAR,  '0,        '0,    '0);
      send_word(OP_EMPTY,  '0,        '0,    '0);
      send_word(OP_FIRST,  '0,        '0,    '0);
      send_word(OP_UNUSED_LO, '1,     '1,    '1);
      send_word(OP_UNUSED_HI, '1,     '1,    '1);
   endtask

   task automatic test_random_with_idling();
      run_random(385);
   endtask

   task automatic test_random_without_idling();
      calm = 1'b1;
      run_random(200);
      calm = 1'b0;
   endtask

   task automatic test_output_backpressure();
      hold_rsp = 1'b1;
      run_random(50);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_bus.ready = calm || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("response word with no request pending");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.flag !== want.flag) begin
               $error("flag: expected %0d, got %0d", want.flag, rsp_bus.flag);
               fail_count++;
            end
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               fail_count++;
            end
            if (rsp_bus.found_member !== want.found_member) begin
               $error("found_member: expected %0d, got %0d",
                      want.found_member, rsp_bus.found_member);
               fail_count++;
            end
            if (rsp_bus.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0d, got %0d",
                      want.out_of_range, rsp_bus.out_of_range);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = '0;
      req_bus.member     = '0;
      req_bus.word_index = '0;
      req_bus.word_value = '0;
      fail_count         = 0;
      quiet_cycles       = 0;
      calm               = 1'b0;
      hold_rsp           = 1'b0;
      model_cursor       = 0;
      foreach (model_words[i])
         model_words[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_with_idling();
      test_random_without_idling();
      test_output_backpressure();
      test_random_with_idling();
      req_bus.valid = 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
sv/bse_pkg.sv
sv/bse_req_if.sv
sv/bse_rsp_if.sv
sv/bse_ram.sv
sv/bse_split.sv
sv/bse_ffs.sv
sv/bitmap_set_engine.sv
verif/tb_top.sv
